FILE: src/mandelbrot_escape_time_pixel_macros.svh
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_MACROS_SVH

// Same-cycle implication, checked only out of reset
`define MEPT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked only out of reset
`define MEPT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/mept_pkg.sv
`timescale 1ns / 1ps

package mept_pkg;

	localparam int FRAC_BITS = 27;
	localparam int COORD_W   = 32;
	localparam int IDX_W     = 12;
	localparam int SPAN_W    = 31;
	localparam int DIM_W     = 13;
	localparam int ITER_W    = 16;
	localparam int GRAY_W    = 8;
	localparam int PROD_W    = 2 * COORD_W;
	localparam int NUM_W     = IDX_W + SPAN_W;
	localparam int DEN_W     = (DIM_W > ITER_W) ? DIM_W : ITER_W;
	localparam int DCNT_W    = $clog2(NUM_W + 1);

	localparam logic [2:0] REG_X_MIN  = 3'd0;
	localparam logic [2:0] REG_Y_MIN  = 3'd1;
	localparam logic [2:0] REG_X_SPAN = 3'd2;
	localparam logic [2:0] REG_Y_SPAN = 3'd3;
	localparam logic [2:0] REG_WIDTH  = 3'd4;
	localparam logic [2:0] REG_HEIGHT = 3'd5;
	localparam logic [2:0] REG_MAXIT  = 3'd6;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [COORD_W:0]   wide_t;

	localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	// Saturate a sum that has grown by one bit back into coordinate range
	function automatic coord_t sat_coord(input wide_t v);
		coord_t r;
		if (v[COORD_W] != v[COORD_W-1]) begin
			r = v[COORD_W] ? COORD_MIN : COORD_MAX;
		end else begin
			r = v[COORD_W-1:0];
		end
		return r;
	endfunction

	function automatic coord_t sat_add(input coord_t a, input coord_t b);
		wide_t s;
		s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
		return sat_coord(s);
	endfunction

endpackage

FILE: src/mept_div.sv
`timescale 1ns / 1ps

module mept_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [mept_pkg::NUM_W-1:0]    numer,
	input  logic [mept_pkg::DEN_W-1:0]    divisor,
	output logic                          done,
	output logic [mept_pkg::NUM_W-1:0]    quotient
);

	logic [mept_pkg::NUM_W-1:0]  num_q;
	logic [mept_pkg::DEN_W-1:0]  den_q;
	logic [mept_pkg::DEN_W-1:0]  rem_q;
	logic [mept_pkg::DCNT_W-1:0] cnt_q;
	logic                        run_q;
	logic                        done_q;
	logic [mept_pkg::DEN_W:0]    trial;
	logic                        fits;

	// one restoring step: bring down the next numerator bit
	assign trial = {rem_q, num_q[mept_pkg::NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= mept_pkg::DCNT_W'(mept_pkg::NUM_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == mept_pkg::DCNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= numer;
			den_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			num_q <= {num_q[mept_pkg::NUM_W-2:0], fits};
			rem_q <= fits ? mept_pkg::DEN_W'(trial - {1'b0, den_q})
			              : trial[mept_pkg::DEN_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

endmodule

FILE: src/mept_mul.sv
`timescale 1ns / 1ps

module mept_mul (
	input  logic             clk,
	input  mept_pkg::coord_t a,
	input  mept_pkg::coord_t b,
	input  logic             dbl,
	output mept_pkg::coord_t res
);

	logic signed [mept_pkg::PROD_W-1:0] prod_s1;
	logic                               dbl_s1;
	logic signed [mept_pkg::PROD_W-1:0] shifted;
	logic                               ovf;
	mept_pkg::coord_t                   res_s2;

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
		dbl_s1  <= dbl;
	end

	// arithmetic shift floors; doubling shifts one place less
	always_comb begin
		shifted = dbl_s1 ? (prod_s1 >>> (mept_pkg::FRAC_BITS - 1))
		                 : (prod_s1 >>> mept_pkg::FRAC_BITS);
		ovf = !((&shifted[mept_pkg::PROD_W-1:mept_pkg::COORD_W-1]) ||
		        (~|shifted[mept_pkg::PROD_W-1:mept_pkg::COORD_W-1]));
	end

	always_ff @(posedge clk) begin
		if (ovf) begin
			res_s2 <= shifted[mept_pkg::PROD_W-1] ? mept_pkg::COORD_MIN : mept_pkg::COORD_MAX;
		end else begin
			res_s2 <= shifted[mept_pkg::COORD_W-1:0];
		end
	end

	assign res = res_s2;

endmodule

FILE: src/mandelbrot_escape_time_pixel.sv
// Each of the three divisions (column map, row map, gray level) runs in the
// bit-serial divider, and each iteration runs on the shared multiplier.
// Throughput: one pixel at a time; busy stays high until the done strobe.
// Reset: asynchronous, active low; the view registers return to their defaults.
// Results are shown for one cycle with done; the receiver cannot stall.
`timescale 1ns / 1ps
`include "mandelbrot_escape_time_pixel_macros.svh"

module mandelbrot_escape_time_pixel (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [mept_pkg::IDX_W-1:0]     pixel_column,
	input  logic [mept_pkg::IDX_W-1:0]     pixel_row,
	input  logic                           cfg_we,
	input  logic [2:0]                     cfg_index,
	input  logic [mept_pkg::COORD_W-1:0]   cfg_data,
	output logic                           done,
	output logic [mept_pkg::ITER_W-1:0]    iteration_count,
	output logic                           limit_reached,
	output logic [mept_pkg::GRAY_W-1:0]    gray_level
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MAPX = 4'd1;
	localparam logic [3:0] S_MAPY = 4'd2;
	localparam logic [3:0] S_XX   = 4'd3;
	localparam logic [3:0] S_YY   = 4'd4;
	localparam logic [3:0] S_XY   = 4'd5;
	localparam logic [3:0] S_CHK  = 4'd6;
	localparam logic [3:0] S_UPD  = 4'd7;
	localparam logic [3:0] S_GRAY = 4'd8;

	localparam logic [mept_pkg::COORD_W:0] FOUR = (mept_pkg::COORD_W+1)'(4) << mept_pkg::FRAC_BITS;

	mept_pkg::coord_t                x_min_q, y_min_q;
	logic [mept_pkg::SPAN_W-1:0]     x_span_q, y_span_q;
	logic [mept_pkg::DIM_W-1:0]      width_q, height_q;
	logic [mept_pkg::ITER_W-1:0]     maxit_q;

	logic [3:0]                      state_q;
	logic [mept_pkg::IDX_W-1:0]      row_q;
	mept_pkg::coord_t                cx_q, cy_q, x_q, y_q, xx_q, diff_q;
	logic [mept_pkg::ITER_W-1:0]     count_q;
	logic                            done_q;
	logic                            limit_q;
	logic [mept_pkg::GRAY_W-1:0]     gray_q;

	logic                            div_start, div_done;
	logic [mept_pkg::NUM_W-1:0]      div_numer, div_quot;
	logic [mept_pkg::DEN_W-1:0]      div_den;
	mept_pkg::coord_t                mul_a, mul_b, mul_res;
	logic                            mul_dbl;

	logic [mept_pkg::DIM_W-1:0]      width_eff, height_eff;
	logic [mept_pkg::ITER_W-1:0]     maxit_eff;
	logic [mept_pkg::ITER_W+mept_pkg::GRAY_W-1:0] gray_num;
	logic [mept_pkg::SPAN_W-1:0]     q_clamped;
	mept_pkg::coord_t                map_base, map_coord;
	logic [mept_pkg::COORD_W:0]      mag_sum;
	logic                            escape, at_limit, accept;

	assign accept    = start && (state_q == S_IDLE);
	assign busy      = (state_q != S_IDLE);
	assign at_limit  = (count_q >= maxit_q);

	assign width_eff  = (width_q == '0)  ? mept_pkg::DIM_W'(1)  : width_q;
	assign height_eff = (height_q == '0) ? mept_pkg::DIM_W'(1)  : height_q;
	assign maxit_eff  = (maxit_q == '0)  ? mept_pkg::ITER_W'(1) : maxit_q;
	assign gray_num   = {count_q, {mept_pkg::GRAY_W{1'b0}}} - {{mept_pkg::GRAY_W{1'b0}}, count_q};

	// squares are never negative, so the sum needs no saturation before compare
	assign mag_sum = {1'b0, xx_q} + {1'b0, mul_res};
	assign escape  = mag_sum > FOUR;

	always_comb begin
		div_numer = mept_pkg::NUM_W'(gray_num);
		div_den   = mept_pkg::DEN_W'(maxit_eff);
		unique case (state_q)
			S_IDLE: begin
				div_numer = mept_pkg::NUM_W'(pixel_column) * mept_pkg::NUM_W'(x_span_q);
				div_den   = mept_pkg::DEN_W'(width_eff);
			end
			S_MAPX: begin
				div_numer = mept_pkg::NUM_W'(row_q) * mept_pkg::NUM_W'(y_span_q);
				div_den   = mept_pkg::DEN_W'(height_eff);
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		unique case (state_q)
			S_MAPX:  div_start = div_done;
			S_XX:    div_start = at_limit;
			S_CHK:   div_start = escape;
			S_IDLE:  div_start = start;
			default: div_start = 1'b0;
		endcase
	end

	always_comb begin
		mul_a   = x_q;
		mul_b   = x_q;
		mul_dbl = 1'b0;
		unique case (state_q)
			S_YY: begin
				mul_a = y_q;
				mul_b = y_q;
			end
			S_XY: begin
				mul_b   = y_q;
				mul_dbl = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// map: clamp the quotient, then add to the view origin
	always_comb begin
		q_clamped = (|div_quot[mept_pkg::NUM_W-1:mept_pkg::SPAN_W])
		            ? {mept_pkg::SPAN_W{1'b1}} : div_quot[mept_pkg::SPAN_W-1:0];
		map_base  = (state_q == S_MAPX) ? x_min_q : y_min_q;
		map_coord = mept_pkg::sat_coord({map_base[mept_pkg::COORD_W-1], map_base}
		                                + {2'b00, q_clamped});
	end

	mept_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.numer    (div_numer),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_quot)
	);

	mept_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.dbl (mul_dbl),
		.res (mul_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q  <= mept_pkg::COORD_W'(32'hE000_0000);
			y_min_q  <= mept_pkg::COORD_W'(32'hE000_0000);
			x_span_q <= mept_pkg::SPAN_W'(31'h4000_0000);
			y_span_q <= mept_pkg::SPAN_W'(31'h4000_0000);
			width_q  <= mept_pkg::DIM_W'(500);
			height_q <= mept_pkg::DIM_W'(500);
			maxit_q  <= mept_pkg::ITER_W'(1000);
		end else if (cfg_we) begin
			unique case (cfg_index)
				mept_pkg::REG_X_MIN:  x_min_q  <= cfg_data;
				mept_pkg::REG_Y_MIN:  y_min_q  <= cfg_data;
				mept_pkg::REG_X_SPAN: x_span_q <= cfg_data[mept_pkg::SPAN_W-1:0];
				mept_pkg::REG_Y_SPAN: y_span_q <= cfg_data[mept_pkg::SPAN_W-1:0];
				mept_pkg::REG_WIDTH:  width_q  <= cfg_data[mept_pkg::DIM_W-1:0];
				mept_pkg::REG_HEIGHT: height_q <= cfg_data[mept_pkg::DIM_W-1:0];
				mept_pkg::REG_MAXIT:  maxit_q  <= cfg_data[mept_pkg::ITER_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (start) state_q <= S_MAPX;
				S_MAPX: if (div_done) state_q <= S_MAPY;
				S_MAPY: if (div_done) state_q <= S_XX;
				S_XX:   state_q <= at_limit ? S_GRAY : S_YY;
				S_YY:   state_q <= S_XY;
				S_XY:   state_q <= S_CHK;
				S_CHK:  state_q <= escape ? S_GRAY : S_UPD;
				S_UPD:  state_q <= S_XX;
				S_GRAY: begin
					if (div_done) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			row_q <= pixel_row;
		end
		if ((state_q == S_MAPX) && div_done) begin
			cx_q <= map_coord;
		end
		if ((state_q == S_MAPY) && div_done) begin
			cy_q    <= map_coord;
			x_q     <= cx_q;
			y_q     <= map_coord;
			count_q <= '0;
		end
		if (state_q == S_XY) begin
			xx_q <= mul_res;
		end
		if (state_q == S_CHK) begin
			diff_q <= mept_pkg::sat_coord({xx_q[mept_pkg::COORD_W-1], xx_q}
			                              - {mul_res[mept_pkg::COORD_W-1], mul_res});
		end
		if (state_q == S_UPD) begin
			x_q     <= mept_pkg::sat_add(diff_q, cx_q);
			y_q     <= mept_pkg::sat_add(mul_res, cy_q);
			count_q <= count_q + 1'b1;
		end
		if ((state_q == S_GRAY) && div_done) begin
			gray_q  <= div_quot[mept_pkg::GRAY_W-1:0];
			limit_q <= at_limit;
		end
	end

	assign done            = done_q;
	assign iteration_count = count_q;
	assign limit_reached   = limit_q;
	assign gray_level      = gray_q;

	`MEPT_ASSERT_NEXT(a_done_single, done_q, !done_q, "result strobe held for more than one cycle")
	`MEPT_ASSERT_NOW(a_done_from_gray, done_q, $past(state_q) == S_GRAY, "result without gray division")
	`MEPT_ASSERT_NOW(a_count_bounded, done_q, count_q <= maxit_q, "iteration count beyond limit")
	`MEPT_ASSERT_NOW(a_upd_below_limit, state_q == S_UPD, count_q < maxit_q, "iteration past limit")
	`MEPT_ASSERT_NEXT(a_accept_maps, accept, state_q == S_MAPX, "accepted pixel not mapped")

endmodule
